// ===== hdl/tspr_pkg.sv =====
// tspr_pkg: shared types, constants and helpers for the tile/sprite pixel renderer
// used by all modules of the renderer; no dependencies
package tspr_pkg;

    localparam int SCREEN_WIDTH_DEF   = 160;
    localparam int SPRITE_COUNT_DEF   = 40;
    localparam int TILE_MEM_BYTES_DEF = 8192;

    localparam int ADDR_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    // item kinds
    typedef enum logic [1:0] {
        ACT_TILE_WR   = 2'd0,
        ACT_SPRITE_WR = 2'd1,
        ACT_RENDER    = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LCDC   = 3'd0,
        REG_SCY    = 3'd1,
        REG_SCX    = 3'd2,
        REG_WY     = 3'd3,
        REG_WX     = 3'd4,
        REG_BGP    = 3'd5,
        REG_OBP0   = 3'd6,
        REG_OBP1   = 3'd7
    } reg_idx_t;

    localparam logic [12:0] MAP_HI_BASE  = 13'h1C00;
    localparam logic [12:0] MAP_LO_BASE  = 13'h1800;
    localparam logic [12:0] SIGNED_BASE  = 13'h0800;

    localparam int LCDC_TALL    = 2;
    localparam int LCDC_BG_MAP  = 3;
    localparam int LCDC_UNSIGN  = 4;
    localparam int LCDC_WIN_EN  = 5;
    localparam int LCDC_WIN_MAP = 6;

    localparam int ATTR_PAL    = 4;
    localparam int ATTR_XFLIP  = 5;
    localparam int ATTR_YFLIP  = 6;
    localparam int ATTR_BEHIND = 7;

    // classified command from front to back
    typedef struct packed {
        action_t     action;
        logic [12:0] address;
        logic [7:0]  data;
        logic [7:0]  pixel_x;
        logic [7:0]  line;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_RD,
        ST_MAP_WAIT,
        ST_BG_LO,
        ST_BG_HI,
        ST_BG_DONE,
        ST_SPR_ATTR,
        ST_SPR_LO,
        ST_SPR_HI,
        ST_SPR_MIX,
        ST_OUT
    } rstate_t;

    function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] num);
        pal_shade = pal[{num, 1'b0} +: 2];
    endfunction

endpackage

// ===== hdl/tspr_queue.sv =====
// tspr_queue: short command queue between the front and the back
// depends on tspr_pkg
module tspr_queue
    import tspr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign in_ready  = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = mem_reg[rp_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) mem_reg[wp_reg] <= in_cmd;
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (in_valid && in_ready) wp_reg <= wp_reg + 1'b1;
            if (out_valid && out_ready) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(in_valid && in_ready)
                               - (PW+1)'(out_valid && out_ready);
        end
    end
endmodule

// ===== hdl/tspr_front.sv =====
// tspr_front: accepts input transfers, drops items that give nothing, forwards the rest
// depends on tspr_pkg
module tspr_front
    import tspr_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF
) (
    input  logic s_valid,
    output logic s_ready,
    input  cmd_t s_cmd,
    output logic q_valid,
    input  logic q_ready,
    output cmd_t q_cmd
);
    logic keep;

    // classify: unused action, out-of-table sprite writes, off-screen pixels
    always_comb begin
        unique case (s_cmd.action)
            ACT_TILE_WR:   keep = 1'b1;
            ACT_SPRITE_WR: keep = ({1'b0, s_cmd.address} < 14'(SPRITE_COUNT * 4));
            ACT_RENDER:    keep = ({1'b0, s_cmd.pixel_x} < 9'(SCREEN_WIDTH));
            default:       keep = 1'b0;
        endcase
    end

    assign q_valid = s_valid && keep;
    assign q_cmd   = s_cmd;
    assign s_ready = q_ready || !keep;
endmodule

// ===== hdl/tspr_back.sv =====
// tspr_back: memories and the pixel sequencer with its output register
// depends on tspr_pkg
module tspr_back
    import tspr_pkg::*;
#(
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  cmd_t       q_cmd,
    input  logic [7:0] regs [8],
    output logic       o_valid,
    input  logic       o_ready,
    output logic [7:0] o_x,
    output logic [7:0] o_line,
    output logic [1:0] o_shade,
    output logic       busy
);
    localparam int SI_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int SA_W = $clog2(SPRITE_COUNT * 4);

    // tile memory, one read port
    logic [7:0] vram [TILE_MEM_BYTES_DEF];
    logic [12:0] vaddr;
    logic        vwe;
    logic [7:0]  vdata_reg;
    always_ff @(posedge aclk) begin
        if (vwe) vram[q_cmd.address] <= q_cmd.data;
        vdata_reg <= vram[vaddr];
    end

    // sprite table: four byte lanes, per-byte valid bit so reset reads zero
    logic [7:0] oam_y [SPRITE_COUNT];
    logic [7:0] oam_x [SPRITE_COUNT];
    logic [7:0] oam_t [SPRITE_COUNT];
    logic [7:0] oam_a [SPRITE_COUNT];
    logic        owe;
    logic [SA_W-1:0] oaddr;
    logic [SI_W-1:0] oidx, spr_reg, spr_next;
    assign oaddr = q_cmd.address[SA_W-1:0];
    assign oidx  = SI_W'(oaddr >> 2);

    always_ff @(posedge aclk) begin
        if (owe) begin
            unique case (oaddr[1:0])
                2'd0: oam_y[oidx] <= q_cmd.data;
                2'd1: oam_x[oidx] <= q_cmd.data;
                2'd2: oam_t[oidx] <= q_cmd.data;
                default: oam_a[oidx] <= q_cmd.data;
            endcase
        end
    end

    // per-byte valid: a byte never written reads zero
    logic [3:0] byte_vld_reg [SPRITE_COUNT];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SPRITE_COUNT; i++) byte_vld_reg[i] <= '0;
        end else if (owe) begin
            byte_vld_reg[oidx][oaddr[1:0]] <= 1'b1;
        end
    end

    // registered sprite entry read, addressed ahead so it tracks spr_reg
    logic [7:0] e_y_reg, e_x_reg, e_t_reg, e_a_reg;
    always_ff @(posedge aclk) begin
        spr_reg <= spr_next;
        e_y_reg <= byte_vld_reg[spr_next][0] ? oam_y[spr_next] : 8'd0;
        e_x_reg <= byte_vld_reg[spr_next][1] ? oam_x[spr_next] : 8'd0;
        e_t_reg <= byte_vld_reg[spr_next][2] ? oam_t[spr_next] : 8'd0;
        e_a_reg <= byte_vld_reg[spr_next][3] ? oam_a[spr_next] : 8'd0;
    end

    rstate_t state_reg, state_next;
    cmd_t    cur_reg;
    logic [7:0]  ypos, xpos;
    logic [12:0] taddr_reg;
    logic [7:0]  lo_reg;
    logic [1:0]  shade_reg;
    logic [2:0]  sbit_reg;
    logic        o_valid_reg;
    logic [7:0]  o_x_reg, o_line_reg;
    logic [1:0]  o_shade_reg;

    logic [7:0] lcdc;
    assign lcdc = regs[REG_LCDC];

    // window select
    logic        win;
    logic [8:0]  x7;
    assign x7  = {1'b0, cur_reg.pixel_x} + 9'd7;
    assign win = lcdc[LCDC_WIN_EN] && (regs[REG_WY] <= cur_reg.line)
                 && (x7 >= {1'b0, regs[REG_WX]});

    // sprite hit test on the registered entry
    logic [8:0] dy, dx;
    logic [3:0] row;
    logic       tall, spr_hit;
    logic [7:0] stile;
    logic [2:0] off;
    assign tall = lcdc[LCDC_TALL];
    assign dy = {1'b0, cur_reg.line} + 9'd16 - {1'b0, e_y_reg};
    assign dx = {1'b0, cur_reg.pixel_x} + 9'd8 - {1'b0, e_x_reg};
    assign spr_hit = (dy < (tall ? 9'd16 : 9'd8)) && (dx < 9'd8);
    assign off = dx[2:0];
    always_comb begin
        row = tall ? dy[3:0] : {1'b0, dy[2:0]};
        if (e_a_reg[ATTR_YFLIP]) row = (tall ? 4'd15 : 4'd7) - row;
        stile = tall ? {e_t_reg[7:1], 1'b0} : e_t_reg;
    end

    logic [1:0] cnum, spal;
    assign cnum = {vdata_reg[sbit_reg], lo_reg[sbit_reg]};
    assign spal = pal_shade(e_a_reg[ATTR_PAL] ? regs[REG_OBP1] : regs[REG_OBP0], cnum);

    logic last_spr;
    assign last_spr = (spr_reg == SI_W'(SPRITE_COUNT - 1));

    // sprite index: restart when idle, step after a miss or a mix
    always_comb begin
        spr_next = spr_reg;
        if (state_reg == ST_IDLE) spr_next = '0;
        else if (state_reg == ST_SPR_ATTR && !spr_hit && !last_spr) spr_next = spr_reg + 1'b1;
        else if (state_reg == ST_SPR_MIX && !last_spr) spr_next = spr_reg + 1'b1;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (q_valid && q_cmd.action == ACT_RENDER) state_next = ST_MAP_RD;
            ST_MAP_RD:   state_next = ST_MAP_WAIT;
            ST_MAP_WAIT: state_next = ST_BG_LO;
            ST_BG_LO:    state_next = ST_BG_HI;
            ST_BG_HI:    state_next = ST_BG_DONE;
            ST_BG_DONE:  state_next = ST_SPR_ATTR;
            ST_SPR_ATTR: state_next = spr_hit ? ST_SPR_LO : (last_spr ? ST_OUT : ST_SPR_ATTR);
            ST_SPR_LO:   state_next = ST_SPR_HI;
            ST_SPR_HI:   state_next = ST_SPR_MIX;
            ST_SPR_MIX:  state_next = last_spr ? ST_OUT : ST_SPR_ATTR;
            ST_OUT:      if (!o_valid_reg || o_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        q_ready = 1'b0;
        vwe = 1'b0;
        owe = 1'b0;
        vaddr = taddr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                vwe = q_valid && (q_cmd.action == ACT_TILE_WR);
                owe = q_valid && (q_cmd.action == ACT_SPRITE_WR);
            end
            ST_MAP_RD: vaddr = (win ? (lcdc[LCDC_WIN_MAP] ? MAP_HI_BASE : MAP_LO_BASE)
                                    : (lcdc[LCDC_BG_MAP] ? MAP_HI_BASE : MAP_LO_BASE))
                               + {3'd0, ypos[7:3], xpos[7:3]};
            ST_BG_HI, ST_SPR_HI: vaddr = taddr_reg + 13'd1;
            default: vaddr = taddr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (o_valid_reg && o_ready) o_valid_reg <= 1'b0;
            if (state_reg == ST_OUT && (!o_valid_reg || o_ready)) o_valid_reg <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: cur_reg <= q_cmd;
            ST_MAP_RD: ;
            ST_MAP_WAIT: begin
                taddr_reg <= (lcdc[LCDC_UNSIGN] ? {1'b0, vdata_reg, 4'd0}
                              : SIGNED_BASE + {1'b0, vdata_reg ^ 8'h80, 4'd0})
                             + {9'd0, ypos[2:0], 1'b0};
                sbit_reg <= 3'd7 - xpos[2:0];
            end
            ST_BG_LO: ;
            ST_BG_HI: lo_reg <= vdata_reg;
            ST_BG_DONE: shade_reg <= pal_shade(regs[REG_BGP], cnum);
            ST_SPR_ATTR: begin
                taddr_reg <= {1'b0, stile, 4'd0} + {8'd0, row, 1'b0};
                sbit_reg <= e_a_reg[ATTR_XFLIP] ? off : 3'd7 - off;
            end
            ST_SPR_LO: ;
            ST_SPR_HI: lo_reg <= vdata_reg;
            ST_SPR_MIX: begin
                if (spal != 2'd0 && (!e_a_reg[ATTR_BEHIND] || shade_reg == 2'd0))
                    shade_reg <= spal;
            end
            ST_OUT: begin
                if (!o_valid_reg || o_ready) begin
                    o_x_reg     <= cur_reg.pixel_x;
                    o_line_reg  <= cur_reg.line;
                    o_shade_reg <= shade_reg;
                end
            end
            default: ;
        endcase
    end

    // background coordinates from the latched request
    always_comb begin
        if (win) begin
            ypos = cur_reg.line - regs[REG_WY];
            xpos = x7[7:0] - regs[REG_WX];
        end else begin
            ypos = regs[REG_SCY] + cur_reg.line;
            xpos = regs[REG_SCX] + cur_reg.pixel_x;
        end
    end

    assign o_valid = o_valid_reg;
    assign o_x     = o_x_reg;
    assign o_line  = o_line_reg;
    assign o_shade = o_shade_reg;
    assign busy    = (state_reg != ST_IDLE);
endmodule

// ===== hdl/tile_sprite_pixel_renderer_unit.sv =====
// Tile and sprite pixel renderer: write items fill tile memory or the sprite table
// when the back end is idle; a render request, taken when idle, fetches the background
// over the single tile-memory read port (map read, map wait, low, high, done), walks
// the sprite table one entry per cycle, pausing at each sprite covering the pixel to
// fetch and mix it (low, high, mix), then posts the result, held while the output
// stalls. Nothing new is taken until the back end is idle; a registered command queue
// sits in front. The sprite table reads as zero after reset. Tile memory must be
// written before it is read. Depends on tspr_pkg and the tspr_* modules.
module tile_sprite_pixel_renderer_unit
    import tspr_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[12:0], data[20:13], pixel_x[28:21], line[36:29], zero fill
    input  logic [39:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_x[7:0], out_line[15:8], shade[17:16], zero fill
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    logic [7:0] regs_reg [8];
    cmd_t s_cmd, q_in, q_out;
    logic f_valid, f_ready, b_valid, b_ready, busy;
    logic [7:0] ox, oline;
    logic [1:0] oshade;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) regs_reg[i] <= '0;
        end else if (cfg_we) begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    assign s_cmd.action  = action_t'(s_tuser);
    assign s_cmd.address = s_tdata[12:0];
    assign s_cmd.data    = s_tdata[20:13];
    assign s_cmd.pixel_x = s_tdata[28:21];
    assign s_cmd.line    = s_tdata[36:29];

    tspr_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SPRITE_COUNT(SPRITE_COUNT)) u_front (
        .s_valid(s_tvalid), .s_ready(s_tready), .s_cmd(s_cmd),
        .q_valid(f_valid), .q_ready(f_ready), .q_cmd(q_in));

    tspr_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(q_in),
        .out_valid(b_valid), .out_ready(b_ready), .out_cmd(q_out));

    tspr_back #(.SPRITE_COUNT(SPRITE_COUNT)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(b_valid), .q_ready(b_ready), .q_cmd(q_out), .regs(regs_reg),
        .o_valid(m_tvalid), .o_ready(m_tready),
        .o_x(ox), .o_line(oline), .o_shade(oshade), .busy(busy));

    assign m_tdata = {6'd0, oshade, oline, ox};

    // a result never carries a column off the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[7:0]} < 9'(SCREEN_WIDTH)))
        else $error("result column off screen");

    // a back stage that takes a command is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid && b_ready) |-> !busy)
        else $error("command taken while busy");

    // the output holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped while stalled");
endmodule
